@@ sv/glm_pkg.sv @@
package glm_pkg;

    // default voxel width
    localparam int PIXEL_BITS_DEF = 16;

    // configuration register map (index of each register, byte address is 4*index)
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_MEAN  = 2'd0;
    localparam logic [1:0] REG_KINV  = 2'd1;
    localparam logic [1:0] REG_PAD   = 2'd2;
    localparam logic [1:0] REG_SCALE = 2'd3;

    // register reset values
    localparam logic [15:0] MEAN_RST  = 16'h0000;
    localparam logic [31:0] KINV_RST  = 32'h0100_0000;
    localparam logic [16:0] PAD_RST   = 17'h1_7FFF;  // -32769 in 17 bit two's complement
    localparam logic [15:0] SCALE_RST = 16'd256;

    // fixed point constants
    localparam int Y_W    = 26;                       // exponent / 256 in q2.30, below 3*2^24
    localparam int T_W    = 31;                       // q2.30 values up to 1.0
    localparam int D2_W   = 28;                       // square of a 14 bit distance
    localparam int PROD_W = D2_W + 32;
    localparam int AD_SMALL_W = 14;                   // distances at or above 2^14 always cut off when k is nonzero
    localparam logic [T_W-1:0]    Q30_ONE    = 31'h4000_0000;
    localparam logic [PROD_W-1:0] EXP_CUTOFF = 60'h000_0000_0C00_0000;  // 12 << 24
    localparam logic [31:0]       DIV3_MUL   = 32'hAAAA_AAAB;           // floor(v*m >> 33) = v/3
    localparam int SQUARINGS = 8;

    // control that travels alongside each pipeline stage
    typedef struct packed {
        logic vld;
        logic pad;
        logic zero;
    } t_glm_tag;

endpackage

@@ sv/glm_exp.sv @@
module glm_exp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  glm_pkg::t_glm_tag        i_tag,
    input  logic [glm_pkg::Y_W-1:0]  i_y,
    output glm_pkg::t_glm_tag        o_tag,
    output logic [glm_pkg::T_W-1:0]  o_e
);

    localparam int YW = glm_pkg::Y_W;
    localparam int TW = glm_pkg::T_W;
    localparam int SQ = glm_pkg::SQUARINGS;
    localparam int STAGES = 6 + SQ;

    glm_pkg::t_glm_tag r_tag [0:STAGES-1];

    // horner stages
    logic [YW-1:0] r_a_y, r_b_y, r_c_y, r_d_y;
    logic [TW-1:0] r_a_t0;
    logic [YW-1:0] r_b_v;
    logic [24:0]   r_c_q;
    logic [YW-1:0] r_d_v;
    logic [YW-1:0] r_e_v;
    logic [TW-1:0] r_sq [0:SQ];

    logic [TW-1:0] n_a_t0;
    logic [56:0]   w_b_prod;
    logic [57:0]   w_c_prod;
    logic [TW-1:0] w_d_t1;
    logic [56:0]   w_d_prod;
    logic [TW-1:0] w_e_t2;
    logic [56:0]   w_e_prod;
    logic [TW-1:0] n_sq [0:SQ];
    logic [61:0]   w_sq_prod [1:SQ];

    always_comb begin
        // t0 = 1 - y/4
        n_a_t0   = glm_pkg::Q30_ONE - TW'(i_y >> 2);
        w_b_prod = r_a_y * r_a_t0;
        w_c_prod = r_b_v * glm_pkg::DIV3_MUL;
        // t1 = 1 - (y*t0)/3
        w_d_t1   = glm_pkg::Q30_ONE - TW'(r_c_q);
        w_d_prod = r_c_y * w_d_t1;
        // t2 = 1 - (y*t1)/2
        w_e_t2   = glm_pkg::Q30_ONE - TW'(r_d_v >> 1);
        w_e_prod = r_d_y * w_e_t2;
        // t3 = 1 - y*t2
        n_sq[0]  = glm_pkg::Q30_ONE - TW'(r_e_v);
        for (int s = 1; s <= SQ; s++) begin
            w_sq_prod[s] = r_sq[s-1] * r_sq[s-1] + 62'h2000_0000;
            n_sq[s]      = w_sq_prod[s][60:30];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) begin
                r_tag[s] <= '0;
            end
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            for (int s = 1; s < STAGES; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_y  <= i_y;
            r_a_t0 <= n_a_t0;
            r_b_y  <= r_a_y;
            r_b_v  <= w_b_prod[55:30];
            r_c_y  <= r_b_y;
            r_c_q  <= w_c_prod[57:33];
            r_d_y  <= r_c_y;
            r_d_v  <= w_d_prod[55:30];
            r_e_v  <= w_e_prod[55:30];
            for (int s = 0; s <= SQ; s++) begin
                r_sq[s] <= n_sq[s];
            end
        end
    end

    assign o_tag = r_tag[STAGES-1];
    assign o_e   = r_sq[SQ];

endmodule

@@ sv/gaussian_likelihood_map_core.sv @@
// path: an accepted item is registered in stages 1 to 3, in the exp pipeline and then in the output register
// throughput: one item per cycle while the output is not stalled; a stalled output freezes the whole pipeline in place
// the rate is set by the 18-stage pipeline with at most one multiplier per stage
// reset: synchronous, active low; clears all stage valid bits and loads register
// defaults (mean 0, k 1.0, pad level -32769, peak scale 256)
module gaussian_likelihood_map_core #(
    parameter int PIXEL_BITS = glm_pkg::PIXEL_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // voxel input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [PIXEL_BITS-1:0]  i_intensity,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [15:0]                   o_likelihood,
    output logic                          o_is_padding,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [glm_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    // width that holds both the voxel and the 17 bit pad level
    localparam int CMP_W = (PIXEL_BITS > 17) ? PIXEL_BITS : 17;
    // width of the signed difference to the mean
    localparam int DW    = ((PIXEL_BITS > 16) ? PIXEL_BITS : 16) + 1;
    localparam int AW    = glm_pkg::AD_SMALL_W;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic signed [15:0] r_mean;
    logic [31:0]        r_kinv;
    logic signed [16:0] r_pad;
    logic [15:0]        r_scale;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= glm_pkg::MEAN_RST;
            r_kinv  <= glm_pkg::KINV_RST;
            r_pad   <= glm_pkg::PAD_RST;
            r_scale <= glm_pkg::SCALE_RST;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                glm_pkg::REG_MEAN:  r_mean  <= pwdata[15:0];
                glm_pkg::REG_KINV:  r_kinv  <= pwdata;
                glm_pkg::REG_PAD:   r_pad   <= pwdata[16:0];
                glm_pkg::REG_SCALE: r_scale <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back raw register bits, zero extended
    always_comb begin
        unique case (paddr[3:2])
            glm_pkg::REG_MEAN:  prdata = {16'h0, r_mean};
            glm_pkg::REG_KINV:  prdata = r_kinv;
            glm_pkg::REG_PAD:   prdata = {15'h0, r_pad};
            glm_pkg::REG_SCALE: prdata = {16'h0, r_scale};
            default:            prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // pipeline enable: every stage moves when the output register is free
    // or its item is being taken
    // ---------------------------------------------------------------
    logic w_en;
    logic r_out_vld;

    assign w_en       = !r_out_vld || i_out_ready;
    assign o_in_ready = w_en;

    // ---------------------------------------------------------------
    // stage 1: pad test and distance to the mean
    // ---------------------------------------------------------------
    logic signed [CMP_W-1:0] w_x_c, w_pad_c;
    logic signed [DW-1:0]    w_x_d, w_mu_d, w_d;
    logic [DW-1:0]           w_ad;
    glm_pkg::t_glm_tag       n_s1_tag, r_s1_tag;
    logic [DW-1:0]           r_s1_ad;

    always_comb begin
        w_x_c   = CMP_W'(i_intensity);
        w_pad_c = CMP_W'(r_pad);
        w_x_d   = DW'(i_intensity);
        w_mu_d  = DW'(r_mean);
        w_d     = w_x_d - w_mu_d;
        w_ad    = w_d[DW-1] ? DW'(-w_d) : DW'(w_d);
        n_s1_tag.vld  = i_in_valid;
        n_s1_tag.pad  = (w_x_c <= w_pad_c);
        n_s1_tag.zero = 1'b0;
    end

    // ---------------------------------------------------------------
    // stage 2: square of the distance; wide distances are flagged, since
    // their exponent is always past the cutoff when k is nonzero
    // ---------------------------------------------------------------
    glm_pkg::t_glm_tag              r_s2_tag;
    logic                           r_s2_big;
    logic [glm_pkg::D2_W-1:0]       r_s2_d2;

    // ---------------------------------------------------------------
    // stage 3: exponent in q.24, d^2 * k
    // ---------------------------------------------------------------
    glm_pkg::t_glm_tag              r_s3_tag;
    logic                           r_s3_big;
    logic [glm_pkg::PROD_W-1:0]     r_s3_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_tag <= '0;
            r_s2_tag <= '0;
            r_s3_tag <= '0;
        end else if (w_en) begin
            r_s1_tag <= n_s1_tag;
            r_s2_tag <= r_s1_tag;
            r_s3_tag <= r_s2_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_ad   <= w_ad;
            r_s2_big  <= |r_s1_ad[DW-1:AW];
            r_s2_d2   <= r_s1_ad[AW-1:0] * r_s1_ad[AW-1:0];
            r_s3_big  <= r_s2_big;
            r_s3_prod <= r_s2_d2 * r_kinv;
        end
    end

    // ---------------------------------------------------------------
    // cutoff test, then the exponential: a degree-4 polynomial in horner
    // form followed by eight squarings, all in q2.30
    // ---------------------------------------------------------------
    glm_pkg::t_glm_tag          w_x_tag, w_e_tag;
    logic [glm_pkg::Y_W-1:0]    w_y;
    logic [glm_pkg::T_W-1:0]    w_e;

    always_comb begin
        w_x_tag      = r_s3_tag;
        w_x_tag.zero = (r_s3_big && (r_kinv != '0)) || (r_s3_prod >= glm_pkg::EXP_CUTOFF);
        // below the cutoff the exponent fits in 28 bits; y = exponent / 256 in q2.30
        w_y          = r_s3_prod[glm_pkg::Y_W+1:2];
    end

    glm_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_tag   (w_x_tag),
        .i_y     (w_y),
        .o_tag   (w_e_tag),
        .o_e     (w_e)
    );

    // ---------------------------------------------------------------
    // output register: scale by peak, round half up, force zero for
    // padding and for exponents past the cutoff
    // ---------------------------------------------------------------
    logic [45:0] w_scaled;
    logic [15:0] r_like;
    logic        r_pad_flag;

    assign w_scaled = w_e * r_scale + 46'h0000_2000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_e_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pad_flag <= w_e_tag.pad;
            r_like     <= (w_e_tag.pad || w_e_tag.zero) ? 16'h0 : w_scaled[45:30];
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_likelihood = r_like;
    assign o_is_padding = r_pad_flag;

endmodule

@@ test/glm_checker.sv @@
module glm_likelihood_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic signed [glm_pkg::PIXEL_BITS_DEF-1:0] i_intensity,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [15:0]                         i_likelihood,
    input  logic                                i_is_padding,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic                                i_pready,
    input  logic [glm_pkg::ADDR_W-1:0]          i_paddr,
    input  logic [31:0]                         i_pwdata,
    output int                                  o_fails,
    output int                                  o_pending,
    output int                                  o_results,
    output int                                  o_padded,
    output int                                  o_nonzero
);

    typedef struct packed {
        logic [15:0] likelihood;
        logic        is_padding;
    } t_voxel_weight;

    localparam logic [63:0] Q30_UNIT     = 64'd1 << 30;
    localparam logic [63:0] Q30_HALF     = 64'd1 << 29;
    localparam logic [63:0] EXPO_LIMIT   = 64'd12 << 24;
    localparam int          SQUARE_STEPS = 8;

    // shadow copy of the register file
    logic signed [15:0] mean_r;
    logic [31:0]        kinv_r;
    logic signed [16:0] pad_r;
    logic [15:0]        peak_r;

    t_voxel_weight weight_q[$];
    int fails, results, padded, nonzero;

    function automatic t_voxel_weight gauss_weight(input logic signed [15:0] x);
        t_voxel_weight      w;
        logic signed [17:0] diff;
        logic [17:0]        mag;
        logic [63:0]        expo, y, t, scaled;
        w.likelihood = '0;
        w.is_padding = 1'b1;
        if (x <= pad_r)
            return w;
        w.is_padding = 1'b0;
        diff = x - mean_r;
        mag  = diff[17] ? 18'(-diff) : 18'(diff);
        expo = 64'(mag) * 64'(mag) * 64'(kinv_r);
        if (expo >= EXPO_LIMIT)
            return w;
        // degree-4 taylor of exp(-e/256) in q2.30, then 8 squarings
        y = expo >> 2;
        t = Q30_UNIT - y / 4;
        t = Q30_UNIT - ((y * t) >> 30) / 3;
        t = Q30_UNIT - ((y * t) >> 30) / 2;
        t = Q30_UNIT - ((y * t) >> 30);
        for (int i = 0; i < SQUARE_STEPS; i++)
            t = (t * t + Q30_HALF) >> 30;
        scaled = (t * 64'(peak_r) + Q30_HALF) >> 30;
        w.likelihood = scaled[15:0];
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_voxel_weight want;
        if (!i_rst_n) begin
            mean_r = 16'sd0;
            kinv_r = 32'h0100_0000;
            pad_r  = -17'sd32769;
            peak_r = 16'd256;
            weight_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[glm_pkg::ADDR_W-1:2])
                    glm_pkg::REG_MEAN:  mean_r = i_pwdata[15:0];
                    glm_pkg::REG_KINV:  kinv_r = i_pwdata;
                    glm_pkg::REG_PAD:   pad_r  = i_pwdata[16:0];
                    glm_pkg::REG_SCALE: peak_r = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                results++;
                if (i_is_padding)
                    padded++;
                if (i_likelihood != 0)
                    nonzero++;
                if (weight_q.size() == 0) begin
                    $error("unexpected result: likelihood %0d is_padding %0b",
                           i_likelihood, i_is_padding);
                    fails++;
                end else begin
                    want = weight_q.pop_front();
                    if (want.likelihood !== i_likelihood) begin
                        $error("likelihood: expected %0d, actual %0d",
                               want.likelihood, i_likelihood);
                        fails++;
                    end
                    if (want.is_padding !== i_is_padding) begin
                        $error("is_padding: expected %0b, actual %0b",
                               want.is_padding, i_is_padding);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                weight_q.push_back(gauss_weight(i_intensity));
        end
        o_fails   <= fails;
        o_pending <= weight_q.size();
        o_results <= results;
        o_padded  <= padded;
        o_nonzero <= nonzero;
    end

endmodule

@@ test/tb_gaussian_likelihood_map_core.sv @@
module tb_gaussian_likelihood_map_core;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // voxel channel
    logic                                  in_valid  = 1'b0;
    logic signed [glm_pkg::PIXEL_BITS_DEF-1:0] intensity = '0;
    logic                                  in_ready;

    // result channel
    logic        out_ready = 1'b0;
    logic        out_valid;
    logic [15:0] likelihood;
    logic        is_padding;

    // register port
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [glm_pkg::ADDR_W-1:0] paddr   = '0;
    logic [31:0]                pwdata  = '0;
    logic [31:0]                prdata;
    logic                       pready;

    // run control shared by the sender and the receiver
    logic steady   = 1'b0;   // no idling on either side while set
    logic hold_arm = 1'b0;   // asks the receiver for one long hold-off

    // current setting, kept so random voxels can be aimed near mean and pad level
    int cur_mean = 0;
    int cur_pad  = -32769;
    int settings = 1;

    // checker feedback
    int fails, pending, results, padded, nonzero;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    gaussian_likelihood_map_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_intensity  (intensity),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_likelihood (likelihood),
        .o_is_padding (is_padding),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    glm_likelihood_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_intensity  (intensity),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_likelihood (likelihood),
        .i_is_padding (is_padding),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fails      (fails),
        .o_pending    (pending),
        .o_results    (results),
        .o_padded     (padded),
        .o_nonzero    (nonzero)
    );

    // receiver: about one idle cycle in ten, none while steady,
    // and a single long hold-off of its own when armed
    int  hold_left  = 0;
    logic hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_arm && !hold_done) begin
            // the pipeline fills up behind this and in_ready drops
            hold_done <= 1'b1;
            hold_left <= 80;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= steady || ($urandom_range(99) >= 10);
        end
    end

    // one apb write: setup cycle, access cycle, then a cycle with psel low
    task automatic reg_write(input logic [1:0] reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one voxel, with an occasional gap in front of it
    task automatic push_voxel(input logic signed [15:0] value);
        if (!steady) begin
            while ($urandom_range(99) < 10) begin
                in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_valid  <= 1'b1;
        intensity <= value;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // every result back before the registers change
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic apply_setting(input int mean, input logic [31:0] kinv,
                                 input int pad, input logic [15:0] scale);
        drain();
        reg_write(glm_pkg::REG_MEAN, 32'(mean));
        reg_write(glm_pkg::REG_KINV, kinv);
        reg_write(glm_pkg::REG_PAD, 32'(pad));
        reg_write(glm_pkg::REG_SCALE, {16'd0, scale});
        cur_mean = mean;
        cur_pad  = pad;
        settings++;
    endtask

    // mostly voxels around the mean at a random scale of distance, so the
    // nonzero part of the curve is hit for any width; some near the pad
    // level and some anywhere in the range
    function automatic logic signed [15:0] pick_voxel();
        int v;
        int span;
        case ($urandom_range(9))
            0, 1: v = int'($urandom_range(65535)) - 32768;
            2:    v = cur_pad + int'($urandom_range(2)) - 1;
            default: begin
                span = 1 << $urandom_range(15);
                v = cur_mean + int'($urandom_range(2 * span)) - span;
            end
        endcase
        if (v < -32768)
            v = -32768;
        if (v > 32767)
            v = 32767;
        return 16'(v);
    endfunction

    task automatic random_voxels(input int count);
        repeat (count)
            push_voxel(pick_voxel());
    endtask

    // safety net against a hung handshake
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        logic signed [15:0] reset_list[$];
        reset_list = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd1, -16'sd1, 16'sd2,
                       -16'sd2, 16'sd3, -16'sd3, 16'sh5555, 16'shAAAA, 16'sd100};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: mean 0, k 1.0, pad level below every voxel, scale 256;
        // anything four or more away from the mean lands past the cutoff
        foreach (reset_list[i])
            push_voxel(reset_list[i]);

        // zero k: every voxel above the pad level gets the full scale;
        // lowest mean, lowest voxel is padding, highest scale
        apply_setting(-32768, 32'h0000_0000, -32768, 16'hFFFF);
        push_voxel(-16'sd32768);
        push_voxel(-16'sd32767);
        push_voxel(16'sd32767);
        push_voxel(16'sd0);
        random_voxels(80);

        // highest mean and k, pad level below every voxel, scale of one
        apply_setting(32767, 32'hFFFF_FFFF, -32769, 16'd1);
        push_voxel(16'sd32767);
        push_voxel(16'sd32766);
        push_voxel(-16'sd32768);
        random_voxels(80);

        // pad level at the highest voxel value: every voxel is padding
        apply_setting(0, 32'h0000_0001, 32767, 16'd500);
        push_voxel(16'sd32767);
        push_voxel(-16'sd32768);
        push_voxel(16'sd0);
        random_voxels(20);

        // back to back on both sides for a while
        apply_setting(1000, 32'h0000_1000, 0, 16'hFFFF);
        steady <= 1'b1;
        random_voxels(200);
        steady <= 1'b0;

        // wide curve; the receiver holds off while voxels keep coming
        apply_setting(-200, 32'h0000_0010, -32769, 16'd40000);
        hold_arm <= 1'b1;
        random_voxels(200);

        // random settings, k spread over many octaves
        repeat (6) begin
            apply_setting(int'($urandom_range(65535)) - 32768,
                          $urandom >> $urandom_range(31),
                          $urandom_range(1) ? -32769 : int'($urandom_range(65536)) - 32769,
                          16'($urandom_range(65535)));
            random_voxels(130);
        end

        drain();
        // let any stray result show up
        repeat (40) @(posedge i_clk);

        $display("checked %0d results over %0d register settings", results, settings);
        $display("%0d padded voxels, %0d nonzero likelihoods", padded, nonzero);
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/glm_pkg.sv
sv/glm_exp.sv
sv/gaussian_likelihood_map_core.sv
test/glm_checker.sv
test/tb_gaussian_likelihood_map_core.sv
